### hw/rtl/chd_pkg.sv
package chd_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int MAX_CODE_LEN = 31;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_W        = 5;
    localparam int SYM_W        = 8;
    localparam int CODE_W       = 31;
    localparam int COUNT_W      = 32;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_BIT   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DECODED  = 2'd0,
        ST_NO_CODE  = 2'd1,
        ST_FULL     = 2'd2,
        ST_RESERVED = 2'd3
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic clear;
    } cell_ctl_t;

endpackage

### hw/rtl/chd_in_if.sv
interface chd_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [chd_pkg::SYM_W-1:0] entry_symbol;
    logic [chd_pkg::LEN_W-1:0] entry_length;
    logic [chd_pkg::CODE_W-1:0] entry_code;
    logic                      data_bit;

    modport source (output valid, req_type, entry_symbol, entry_length, entry_code, data_bit,
                    input ready);
    modport sink   (input valid, req_type, entry_symbol, entry_length, entry_code, data_bit,
                    output ready);
endinterface

interface chd_out_if;
    logic                      valid;
    logic                      ready;
    logic [chd_pkg::SYM_W-1:0] decoded_symbol;
    logic [1:0]                status;
    logic                      last_symbol;

    modport source (output valid, decoded_symbol, status, last_symbol, input ready);
    modport sink   (input valid, decoded_symbol, status, last_symbol, output ready);
endinterface

interface chd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [chd_pkg::COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/chd_cell.sv
// One sorted table slot. Insert shifts the row right from the insertion point.
module chd_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  chd_pkg::cell_ctl_t        ctl,
    input  chd_pkg::entry_t           key,
    input  chd_pkg::entry_t           prev_entry,
    input  logic                      prev_valid,
    input  logic                      prev_after,
    input  logic [chd_pkg::LEN_W-1:0] acc_len,
    input  logic [chd_pkg::CODE_W-1:0] acc_code,
    output chd_pkg::entry_t           entry,
    output logic                      valid,
    output logic                      after,
    output logic                      match,
    output logic                      longer
);
    chd_pkg::entry_t entry_reg, entry_next;
    logic            valid_reg, valid_next;

    // invalid slots order after any key
    assign after  = !valid_reg || (entry_reg > key);
    assign match  = valid_reg && (entry_reg.len == acc_len) && (entry_reg.code == acc_code);
    assign longer = valid_reg && (entry_reg.len > acc_len);
    assign entry  = entry_reg;
    assign valid  = valid_reg;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.insert)
        begin
            if (prev_after)
            begin
                entry_next = prev_entry;
                valid_next = prev_valid;
            end
            else if (after)
            begin
                entry_next = key;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end
endmodule

### hw/rtl/canonical_huffman_decoder.sv
// Channel  | Dir | Payload                                              | Transfer
// in_ch    | in  | req_type, entry_symbol, entry_length, entry_code,    | valid & ready
//          |     | data_bit                                             |
// out_ch   | out | decoded_symbol, status, last_symbol                  | valid & ready
// cfg_ch   | in  | data (symbol_count)                                  | valid & ready
//
// Steps: load, clear, ignored items and bit items past symbol_count end in S_IDLE; any
// other bit item passes accept, registered compare across the cell row, and priority
// select. An item that yields a result holds off in_ch until the result transfers.
// The row of MAX_ENTRIES cells sets the priority select depth.
// Reset: async active low; table empty, counters zero, symbol_count zero.
// Stalls: no transfer is taken on in_ch while a result waits on out_ch.
module canonical_huffman_decoder (
    input  logic      clk,
    input  logic      rst_n,
    chd_in_if.sink    in_ch,
    chd_out_if.source out_ch,
    chd_cfg_if.sink   cfg_ch
);
    localparam int N = chd_pkg::MAX_ENTRIES;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SEL} state_t;

    state_t                          state_reg;
    logic [chd_pkg::COUNT_W-1:0]     count_reg;
    logic [chd_pkg::COUNT_W-1:0]     done_reg;
    logic [chd_pkg::CNT_W-1:0]       total_reg;
    logic [chd_pkg::CODE_W-1:0]      acc_code_reg;
    logic [chd_pkg::LEN_W-1:0]       acc_len_reg;
    logic [N-1:0]                    match_reg;
    logic                            longer_reg;
    logic                            out_valid_reg;
    logic [chd_pkg::SYM_W-1:0]       out_sym_reg;
    logic [1:0]                      out_status_reg;
    logic                            out_last_reg;

    chd_pkg::entry_t                 entries [N];
    logic [N-1:0]                    valids, afters, hit_vec, longers;
    chd_pkg::cell_ctl_t              ctl;
    chd_pkg::entry_t                 key;
    logic [chd_pkg::CODE_W-1:0]      code_mask;
    logic                            in_xfer, len_ok, full, stream_done;
    logic                            sel_hit;
    logic [chd_pkg::SYM_W-1:0]       sel_sym;
    logic [chd_pkg::COUNT_W:0]       done_inc;

    assign in_ch.ready    = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ch.ready   = 1'b1;
    assign in_xfer        = in_ch.valid && in_ch.ready;
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.decoded_symbol = out_sym_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.last_symbol    = out_last_reg;

    // keep only the low entry_length bits of the code
    assign code_mask = ~(chd_pkg::CODE_W'({chd_pkg::COUNT_W{1'b1}} << in_ch.entry_length));
    assign key.len   = in_ch.entry_length;
    assign key.sym   = in_ch.entry_symbol;
    assign key.code  = in_ch.entry_code & code_mask;

    assign len_ok      = (in_ch.entry_length != '0) &&
                         (in_ch.entry_length <= chd_pkg::LEN_W'(chd_pkg::MAX_CODE_LEN));
    assign full        = (total_reg == chd_pkg::CNT_W'(N));
    assign stream_done = (done_reg >= count_reg);
    assign done_inc    = {1'b0, done_reg} + 1'b1;

    assign ctl.clear  = in_xfer && (in_ch.req_type == chd_pkg::REQ_CLEAR);
    assign ctl.insert = in_xfer && (in_ch.req_type == chd_pkg::REQ_LOAD) && len_ok && !full;

    // the cell row: each cell hands its entry and ordering flag to the next
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            chd_cell u_cell (
                .clk, .rst_n, .ctl, .key,
                .prev_entry (key),
                .prev_valid (1'b0),
                .prev_after (1'b0),
                .acc_len    (acc_len_reg),
                .acc_code   (acc_code_reg),
                .entry      (entries[i]),
                .valid      (valids[i]),
                .after      (afters[i]),
                .match      (hit_vec[i]),
                .longer     (longers[i])
            );
        end
        else
        begin : g_body
            chd_cell u_cell (
                .clk, .rst_n, .ctl, .key,
                .prev_entry (entries[i-1]),
                .prev_valid (valids[i-1]),
                .prev_after (afters[i-1]),
                .acc_len    (acc_len_reg),
                .acc_code   (acc_code_reg),
                .entry      (entries[i]),
                .valid      (valids[i]),
                .after      (afters[i]),
                .match      (hit_vec[i]),
                .longer     (longers[i])
            );
        end
    end

    // first match in table order wins
    always_comb
    begin
        sel_hit = 1'b0;
        sel_sym = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                sel_hit = 1'b1;
                sel_sym = entries[i].sym;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            done_reg       <= '0;
            total_reg      <= '0;
            acc_code_reg   <= '0;
            acc_len_reg    <= '0;
            match_reg      <= '0;
            longer_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_sym_reg    <= '0;
            out_status_reg <= chd_pkg::ST_DECODED;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                count_reg <= cfg_ch.data;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (in_ch.req_type)
                            chd_pkg::REQ_CLEAR:
                            begin
                                total_reg    <= '0;
                                acc_code_reg <= '0;
                                acc_len_reg  <= '0;
                                done_reg     <= '0;
                            end
                            chd_pkg::REQ_LOAD:
                            begin
                                if (len_ok && full)
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_sym_reg    <= '0;
                                    out_status_reg <= chd_pkg::ST_FULL;
                                    out_last_reg   <= 1'b0;
                                end
                                else if (len_ok)
                                begin
                                    total_reg <= total_reg + 1'b1;
                                end
                            end
                            chd_pkg::REQ_BIT:
                            begin
                                if (!stream_done)
                                begin
                                    acc_code_reg <= {acc_code_reg[chd_pkg::CODE_W-2:0],
                                                     in_ch.data_bit};
                                    acc_len_reg  <= acc_len_reg + 1'b1;
                                    state_reg    <= S_EVAL;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_EVAL:
                begin
                    match_reg  <= hit_vec;
                    longer_reg <= |longers;
                    state_reg  <= S_SEL;
                end
                S_SEL:
                begin
                    state_reg <= S_IDLE;
                    if (sel_hit)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sym_reg    <= sel_sym;
                        out_status_reg <= chd_pkg::ST_DECODED;
                        out_last_reg   <= (done_inc >= {1'b0, count_reg});
                        done_reg       <= done_inc[chd_pkg::COUNT_W-1:0];
                        acc_code_reg   <= '0;
                        acc_len_reg    <= '0;
                    end
                    else if (!longer_reg)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sym_reg    <= '0;
                        out_status_reg <= chd_pkg::ST_NO_CODE;
                        out_last_reg   <= 1'b0;
                        acc_code_reg   <= '0;
                        acc_len_reg    <= '0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // table count never exceeds its capacity
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= chd_pkg::CNT_W'(N))
        else $error("entry count overflow");

    // an accepted bit item always passes from the compare stage (S_EVAL) to the select stage (S_SEL)
    a_eval_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |=> state_reg == S_SEL)
        else $error("compare stage skipped select");

    // the valid cell count tracks the entry counter
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valids) == int'(total_reg))
        else $error("cell valid bits disagree with entry count");
endmodule

### dv/chd_tb_if.sv
// Interfaces are provided by the RTL (chd_in_if, chd_out_if, chd_cfg_if); this file only
// holds a small shared package of testbench types.
package chd_tb_pkg;
    typedef struct {
        logic [1:0]                 req;
        logic [chd_pkg::SYM_W-1:0]  sym;
        logic [chd_pkg::LEN_W-1:0]  len;
        logic [chd_pkg::CODE_W-1:0] code;
        logic                       bit_in;
        logic                       has_fixed;
        logic                       fixed_has;
        logic [chd_pkg::SYM_W-1:0]  fixed_sym;
        logic [1:0]                 fixed_status;
        logic                       fixed_last;
    } stim_row_t;

    typedef struct packed {
        logic [chd_pkg::SYM_W-1:0] sym;
        logic [1:0]                status;
        logic                      last;
    } decode_result_t;
endpackage

### dv/canonical_huffman_decoder_tb.sv
module canonical_huffman_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 160;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #2 clk = ~clk;

    chd_in_if  in_ch ();
    chd_out_if out_ch ();
    chd_cfg_if cfg_ch ();

    canonical_huffman_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // ---------------- predictor state ----------------
    logic [chd_pkg::LEN_W-1:0]   tbl_len  [chd_pkg::MAX_ENTRIES];
    logic [chd_pkg::SYM_W-1:0]   tbl_sym  [chd_pkg::MAX_ENTRIES];
    logic [chd_pkg::CODE_W-1:0]  tbl_code [chd_pkg::MAX_ENTRIES];
    int                          n_entries;
    logic [chd_pkg::CODE_W-1:0]  bits_code;
    logic [chd_pkg::LEN_W-1:0]   bits_len;
    int                          scan_at;
    logic [chd_pkg::COUNT_W-1:0] decoded_total;
    logic [chd_pkg::COUNT_W-1:0] symbol_limit;

    chd_tb_pkg::decode_result_t expected_results[$];

    int  mismatches = 0;
    int  cycles = 0;
    int  items_sent = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic done = 1'b0;

    // what the test believes the current table holds, for building valid streams
    logic [chd_pkg::LEN_W-1:0]  known_len  [$];
    logic [chd_pkg::CODE_W-1:0] known_code [$];

    function automatic void reset_decoder_model(input bit full_reset);
        if (full_reset) symbol_limit = '0;
        n_entries = 0;
        bits_code = '0;
        bits_len = '0;
        scan_at = 0;
        decoded_total = '0;
    endfunction

    // true when table entry i sorts after the given key
    function automatic bit sorts_after(input int i, input logic [chd_pkg::LEN_W-1:0] l,
                                       input logic [chd_pkg::SYM_W-1:0] s,
                                       input logic [chd_pkg::CODE_W-1:0] c);
        if (tbl_len[i] != l) return tbl_len[i] > l;
        if (tbl_sym[i] != s) return tbl_sym[i] > s;
        return tbl_code[i] > c;
    endfunction

    // advance the predictor by one transfer; returns 1 when a result is due
    function automatic bit decode_step(input chd_tb_pkg::stim_row_t row,
                                       output chd_tb_pkg::decode_result_t r);
        int pos;
        int p;
        logic [chd_pkg::CODE_W-1:0] masked;
        r = '0;
        case (row.req)
            chd_pkg::REQ_CLEAR:
            begin
                reset_decoder_model(1'b0);
                return 1'b0;
            end
            chd_pkg::REQ_LOAD:
            begin
                if (row.len == '0) return 1'b0;
                if (n_entries >= chd_pkg::MAX_ENTRIES)
                begin
                    r.status = chd_pkg::ST_FULL;
                    return 1'b1;
                end
                masked = (row.len == chd_pkg::LEN_W'(chd_pkg::MAX_CODE_LEN)) ? row.code :
                         (row.code & ((31'd1 << row.len) - 31'd1));
                pos = 0;
                while (pos < n_entries && !sorts_after(pos, row.len, row.sym, masked)) pos++;
                for (int i = n_entries; i > pos; i--)
                begin
                    tbl_len[i]  = tbl_len[i-1];
                    tbl_sym[i]  = tbl_sym[i-1];
                    tbl_code[i] = tbl_code[i-1];
                end
                tbl_len[pos] = row.len;
                tbl_sym[pos] = row.sym;
                tbl_code[pos] = masked;
                n_entries++;
                scan_at = 0;
                return 1'b0;
            end
            chd_pkg::REQ_BIT:
            begin
                if (decoded_total >= symbol_limit) return 1'b0;
                bits_code = {bits_code[chd_pkg::CODE_W-2:0], row.bit_in};
                bits_len = bits_len + 1'b1;
                p = scan_at;
                while (p < n_entries && tbl_len[p] < bits_len) p++;
                while (p < n_entries && tbl_len[p] == bits_len)
                begin
                    if (tbl_code[p] == bits_code)
                    begin
                        r.sym = tbl_sym[p];
                        r.status = chd_pkg::ST_DECODED;
                        bits_code = '0;
                        bits_len = '0;
                        scan_at = 0;
                        decoded_total = decoded_total + 1'b1;
                        r.last = (decoded_total >= symbol_limit);
                        return 1'b1;
                    end
                    p++;
                end
                scan_at = p;
                if (p >= n_entries)
                begin
                    bits_code = '0;
                    bits_len = '0;
                    scan_at = 0;
                    r.status = chd_pkg::ST_NO_CODE;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------- drivers ----------------
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.req_type = chd_pkg::REQ_NONE;
        in_ch.entry_symbol = '0;
        in_ch.entry_length = '0;
        in_ch.entry_code = '0;
        in_ch.data_bit = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
    end

    // receiver: random stall rate per phase
    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // checker: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        chd_tb_pkg::decode_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result sym=%0d status=%0d last=%0d",
                             out_ch.decoded_symbol, out_ch.status, out_ch.last_symbol);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.decoded_symbol !== want.sym || out_ch.status !== want.status ||
                    out_ch.last_symbol !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp sym=%0d st=%0d last=%0d got sym=%0d st=%0d %s%0d",
                                 want.sym, want.status, want.last, out_ch.decoded_symbol,
                                 out_ch.status, "last=", out_ch.last_symbol);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT && !done)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_symbol_count(input logic [chd_pkg::COUNT_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        symbol_limit = v;
    endtask

    // one input transfer; valid stays high until the next idle cycle or pause
    task automatic send_item(input chd_tb_pkg::stim_row_t row);
        chd_tb_pkg::decode_result_t r;
        bit due;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= row.req;
        in_ch.entry_symbol <= row.sym;
        in_ch.entry_length <= row.len;
        in_ch.entry_code <= row.code;
        in_ch.data_bit <= row.bit_in;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
        due = decode_step(row, r);
        if (row.has_fixed)
        begin
            // typed-in expectation must agree with the predictor too
            if (due != row.fixed_has || (due && (r.sym != row.fixed_sym ||
                r.status != row.fixed_status || r.last != row.fixed_last)))
            begin
                mismatches++;
                if (mismatches <= 10) $display("predictor disagrees with directed row");
            end
        end
        if (due) expected_results.push_back(r);
    endtask

    function automatic chd_tb_pkg::stim_row_t mk(input logic [1:0] rq, input int s,
                                                 input int l,
                                                 input logic [chd_pkg::CODE_W-1:0] c,
                                                 input logic b);
        chd_tb_pkg::stim_row_t x;
        x.req = rq; x.sym = chd_pkg::SYM_W'(s); x.len = chd_pkg::LEN_W'(l);
        x.code = c; x.bit_in = b;
        x.has_fixed = 1'b0; x.fixed_has = 1'b0; x.fixed_sym = '0; x.fixed_status = '0;
        x.fixed_last = 1'b0;
        return x;
    endfunction

    function automatic chd_tb_pkg::stim_row_t fx(input chd_tb_pkg::stim_row_t x,
                                                 input logic h, input int s,
                                                 input chd_pkg::status_t st, input logic l);
        x.has_fixed = 1'b1; x.fixed_has = h; x.fixed_sym = chd_pkg::SYM_W'(s);
        x.fixed_status = st; x.fixed_last = l;
        return x;
    endfunction

    task automatic idle_input();
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        idle_input();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_entry(input int s, input int l, input logic [chd_pkg::CODE_W-1:0] c);
        logic [chd_pkg::CODE_W-1:0] kept;
        kept = (l == chd_pkg::MAX_CODE_LEN) ? c : (c & ((31'd1 << l) - 31'd1));
        send_item(mk(chd_pkg::REQ_LOAD, s, l, c, 1'b0));
        known_len.push_back(chd_pkg::LEN_W'(l));
        known_code.push_back(kept);
    endtask

    // random prefix-free-ish table: a canonical set of small lengths
    task automatic load_random_table();
        int n;
        int l;
        logic [chd_pkg::CODE_W-1:0] c;
        known_len.delete();
        known_code.delete();
        send_item(mk(chd_pkg::REQ_CLEAR, 0, 0, '0, 1'b0));
        n = int'($urandom_range(2, 10));
        c = '0;
        l = 1;
        for (int i = 0; i < n; i++)
        begin
            // canonical code: bump length occasionally
            if (i > 0) c = c + 1'b1;
            if ($urandom_range(2) == 0 || c >= (31'd1 << l) - 31'd1)
            begin
                c = c << 1;
                l++;
            end
            if ($urandom_range(40) == 0)
                load_entry(int'($urandom_range(255)), int'($urandom_range(1, 31)),
                           31'($urandom >> 1));
            else
                load_entry(int'($urandom_range(255)), l, c | (31'($urandom) << l));
        end
    endtask

    // bits of one random known code, or noise
    task automatic send_codeword();
        int k;
        if (known_len.size() == 0 || $urandom_range(9) == 0)
        begin
            send_item(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'($urandom_range(1))));
            return;
        end
        k = int'($urandom_range(known_len.size() - 1));
        for (int i = int'(known_len[k]) - 1; i >= 0; i--)
            send_item(mk(chd_pkg::REQ_BIT, 0, 0, '0, known_code[k][i]));
    endtask

    initial
    begin
        chd_tb_pkg::stim_row_t rows[$];
        int phase_end;
        bit paused;
        reset_decoder_model(1'b1);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // symbol_count 0 after reset: bits are dropped
        rows.push_back(fx(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b1), 1'b0, 0,
                          chd_pkg::ST_DECODED, 1'b0));
        foreach (rows[i]) send_item(rows[i]);
        rows.delete();
        drain();
        write_symbol_count(32'd3);
        // empty table: no-code error
        rows.push_back(fx(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b0), 1'b1, 0,
                          chd_pkg::ST_NO_CODE, 1'b0));
        rows.push_back(fx(mk(chd_pkg::REQ_NONE, 0, 5, '0, 1'b0), 1'b0, 0,
                          chd_pkg::ST_DECODED, 1'b0));
        rows.push_back(fx(mk(chd_pkg::REQ_LOAD, 9, 0, '0, 1'b0), 1'b0, 0,
                          chd_pkg::ST_DECODED, 1'b0)); // zero length
        rows.push_back(mk(chd_pkg::REQ_LOAD, 8'hff, 1, 31'h7fff_ffff, 1'b0)); // code too wide
        rows.push_back(mk(chd_pkg::REQ_LOAD, 8'h00, 2, 31'd0, 1'b0));
        rows.push_back(mk(chd_pkg::REQ_LOAD, 8'h55, 31, 31'h7fff_fffe, 1'b0));
        rows.push_back(fx(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b1), 1'b1, 8'hff,
                          chd_pkg::ST_DECODED, 1'b0));
        rows.push_back(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b0));
        rows.push_back(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b0));
        rows.push_back(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b0)); // mid-code
        rows.push_back(mk(chd_pkg::REQ_CLEAR, 0, 0, '0, 1'b0));
        rows.push_back(fx(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b1), 1'b1, 0,
                          chd_pkg::ST_NO_CODE, 1'b0));
        rows.push_back(mk(chd_pkg::REQ_LOAD, 8'h55, 31, 31'h7fff_ffff, 1'b0));
        foreach (rows[i]) send_item(rows[i]);
        rows.delete();
        for (int i = 0; i < 31; i++)
            send_item(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b1)); // longest code
        drain();
        // table full
        send_item(mk(chd_pkg::REQ_CLEAR, 0, 0, '0, 1'b0));
        for (int i = 0; i < chd_pkg::MAX_ENTRIES; i++)
            send_item(mk(chd_pkg::REQ_LOAD, i, int'($urandom_range(1, 31)),
                         31'($urandom >> 1), 1'b0));
        send_item(fx(mk(chd_pkg::REQ_LOAD, 1, 4, 31'd3, 1'b0), 1'b1, 0,
                     chd_pkg::ST_FULL, 1'b0));
        drain();
        // count lowered below symbols done
        send_item(mk(chd_pkg::REQ_CLEAR, 0, 0, '0, 1'b0));
        send_item(mk(chd_pkg::REQ_LOAD, 7, 1, 31'd1, 1'b0));
        send_item(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b1));
        drain();
        write_symbol_count(32'd0);
        send_item(fx(mk(chd_pkg::REQ_BIT, 0, 0, '0, 1'b1), 1'b0, 0,
                     chd_pkg::ST_DECODED, 1'b0));
        drain();
        write_symbol_count(32'hffff_ffff);

        // ---- random part, idling phases ----
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                3: begin send_idle_pct = 15; recv_stall_pct = 15; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            drain();
            if (ph == 3) write_symbol_count(32'($urandom_range(5, 40)));
            if (ph == 4) write_symbol_count(32'hffff_ffff);
            load_random_table();
            phase_end = items_sent + ITEMS_PER_PHASE;
            paused = 1'b0;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(30) == 0) load_random_table();
                else if ($urandom_range(60) == 0)
                    send_item(mk(2'($urandom_range(3)), int'($urandom_range(255)),
                                 int'($urandom_range(31)), 31'($urandom >> 1),
                                 1'($urandom_range(1))));
                else send_codeword();
                if (!paused && items_sent >= phase_end - ITEMS_PER_PHASE / 2)
                begin
                    // sender holds off until every result is back
                    paused = 1'b1;
                    idle_input();
                    do @(posedge clk); while (expected_results.size() != 0);
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        done = 1'b1;
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/chd_pkg.sv
hw/rtl/chd_in_if.sv
hw/rtl/chd_cell.sv
hw/rtl/canonical_huffman_decoder.sv
dv/chd_tb_if.sv
dv/canonical_huffman_decoder_tb.sv
